### rtl/modular_matrix_multiply_power_core_defines.svh
`ifndef MODULAR_MATRIX_MULTIPLY_POWER_CORE_DEFINES_SVH
`define MODULAR_MATRIX_MULTIPLY_POWER_CORE_DEFINES_SVH

// Concurrent checks sampled on clk and disabled while arst_n is low.
`define MMP_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define MMP_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

### rtl/mmp_pkg.sv
`timescale 1ns / 1ps

package mmp_pkg;

	localparam int MAX_DIM   = 8;
	localparam int DIM_W     = 3;
	localparam int DATA_W    = 64;
	localparam int MOD_W     = 62;
	localparam int EXP_W     = 63;
	localparam int FUNC_W    = 3;
	localparam int CFG_IDX_W = 3;
	localparam int REGION_W  = 3;
	localparam int REGIONS   = 5;
	localparam int ADDR_W    = REGION_W + 2 * DIM_W;
	localparam int MEM_DEPTH = REGIONS * MAX_DIM * MAX_DIM;

	localparam logic [FUNC_W-1:0] FN_LOAD_A = 3'd0;
	localparam logic [FUNC_W-1:0] FN_LOAD_B = 3'd1;
	localparam logic [FUNC_W-1:0] FN_ADD    = 3'd2;
	localparam logic [FUNC_W-1:0] FN_SUB    = 3'd3;
	localparam logic [FUNC_W-1:0] FN_MUL    = 3'd4;
	localparam logic [FUNC_W-1:0] FN_POW    = 3'd5;

	localparam logic [REGION_W-1:0] RG_A    = 3'd0;
	localparam logic [REGION_W-1:0] RG_B    = 3'd1;
	localparam logic [REGION_W-1:0] RG_ACC  = 3'd2;
	localparam logic [REGION_W-1:0] RG_BASE = 3'd3;
	localparam logic [REGION_W-1:0] RG_SCR  = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_MOD_EN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INNER   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS_B  = 3'd4;

	localparam logic [MOD_W-1:0] MODULUS_RESET = 62'd1000000007;

	typedef enum logic [1:0] {AOP_ADD, AOP_SUB, AOP_MAC} aop_t;

	typedef enum logic [2:0] {WS_VALUE, WS_ARITH, WS_RD0, WS_ONE, WS_ZERO} wsrc_t;

	typedef enum logic [1:0] {AR_IDLE, AR_RED, AR_MUL, AR_FIN} arith_state_t;

	typedef enum logic [4:0] {
		S_IDLE, S_LOAD,
		S_EW_RD, S_EW_GO, S_EW_WAIT,
		S_MM_RD, S_MM_GO, S_MM_WAIT, S_CP_RD, S_CP_WR, S_MM_RET,
		S_PI_RD, S_PI_WB, S_PI_WI, S_PW_CHK,
		S_EM_RD, S_EM_LD, S_EM_OUT, S_ERR_LD, S_ERR_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic              capture;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr0;
		logic [ADDR_W-1:0] rd_addr1;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		wsrc_t             wr_src;
		logic              ar_start;
		aop_t              ar_op;
		logic              acc_zero;
		logic              p_shift;
		logic              out_load;
		logic [DIM_W-1:0]  out_row;
		logic [DIM_W-1:0]  out_col;
		logic              out_last;
		logic              out_err;
	} dp_cmd_t;

	typedef struct packed {
		logic ar_done;
		logic p_zero;
		logic p_lsb;
		logic p_hi_zero;
	} dp_status_t;

	// Dimension register to its largest index, with 0 taken as 1 and large values as MAX_DIM.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [3:0] v);
		logic [DIM_W-1:0] r;
		if (v == 4'd0)
			r = '0;
		else if (v > 4'(MAX_DIM))
			r = DIM_W'(MAX_DIM - 1);
		else
			r = DIM_W'(v - 4'd1);
		return r;
	endfunction

endpackage

### rtl/mmp_in_if.sv
`timescale 1ns / 1ps

interface mmp_in_if import mmp_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [FUNC_W-1:0]        func;
	logic [DIM_W-1:0]         row;
	logic [DIM_W-1:0]         col;
	logic signed [DATA_W-1:0] value;
	logic [EXP_W-1:0]         exponent;

	modport source (output valid, func, row, col, value, exponent, input ready);
	modport sink (input valid, func, row, col, value, exponent, output ready);
endinterface

### rtl/mmp_out_if.sv
`timescale 1ns / 1ps

interface mmp_out_if import mmp_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [DIM_W-1:0]         out_row;
	logic [DIM_W-1:0]         out_col;
	logic signed [DATA_W-1:0] out_value;
	logic                     last;
	logic                     error;

	modport source (output valid, out_row, out_col, out_value, last, error, input ready);
	modport sink (input valid, out_row, out_col, out_value, last, error, output ready);
endinterface

### rtl/mmp_arith.sv
`timescale 1ns / 1ps

module mmp_arith import mmp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  aop_t              op,
	input  logic [DATA_W-1:0] a,
	input  logic [DATA_W-1:0] b,
	input  logic [DATA_W-1:0] acc,
	input  logic              mod_en,
	input  logic [MOD_W-1:0]  m,
	output logic              done,
	output logic [DATA_W-1:0] result
);

	arith_state_t state_q, state_d;

	logic [5:0]        cnt_q;
	aop_t              op_q;
	logic              mod_q, nega_q, negb_q, done_q;
	logic [DATA_W-1:0] na_q, nb_q, x_q, y_q, r_q, acc_q, res_q;
	logic [MOD_W-1:0]  ra_q, rb_q;

	logic [DATA_W-1:0] m64;
	logic [MOD_W:0]    ta, tb, mx;
	logic [MOD_W-1:0]  ra_n, rb_n, fa, fb;
	logic [DATA_W-1:0] rs, rm, r_n, xs, x_n, y_n, s, fin;

	assign m64 = DATA_W'(m);
	assign mx  = {1'b0, m};

	// One bit of the remainder for each operand per cycle.
	always_comb begin
		ta   = {ra_q, na_q[DATA_W-1]};
		tb   = {rb_q, nb_q[DATA_W-1]};
		ra_n = (ta >= mx) ? MOD_W'(ta - mx) : ta[MOD_W-1:0];
		rb_n = (tb >= mx) ? MOD_W'(tb - mx) : tb[MOD_W-1:0];
		fa   = (nega_q && ra_n != '0) ? m - ra_n : ra_n;
		fb   = (negb_q && rb_n != '0) ? m - rb_n : rb_n;
	end

	// Double-and-add step; without reduction it is a plain shift-and-add.
	always_comb begin
		rs  = r_q + x_q;
		rm  = (mod_q && rs >= m64) ? rs - m64 : rs;
		r_n = y_q[0] ? rm : r_q;
		xs  = x_q + x_q;
		x_n = (mod_q && xs >= m64) ? xs - m64 : xs;
		y_n = y_q >> 1;
	end

	always_comb begin
		s   = '0;
		fin = '0;
		case (op_q)
			AOP_ADD: begin
				s   = x_q + y_q;
				fin = (mod_q && s >= m64) ? s - m64 : s;
			end
			AOP_SUB: begin
				fin = (mod_q && x_q < y_q) ? x_q + (m64 - y_q) : x_q - y_q;
			end
			AOP_MAC: begin
				s   = acc_q + r_q;
				fin = (mod_q && s >= m64) ? s - m64 : s;
			end
			default: fin = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= AR_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == AR_FIN);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			AR_IDLE: begin
				if (start)
					state_d = mod_en ? AR_RED : ((op == AOP_MAC) ? AR_MUL : AR_FIN);
			end
			AR_RED: begin
				if (cnt_q == '1)
					state_d = (op_q == AOP_MAC) ? AR_MUL : AR_FIN;
			end
			AR_MUL: begin
				if (y_n == '0)
					state_d = AR_FIN;
			end
			AR_FIN: state_d = AR_IDLE;
			default: state_d = AR_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			AR_IDLE: begin
				if (start) begin
					op_q   <= op;
					acc_q  <= acc;
					mod_q  <= mod_en;
					x_q    <= a;
					y_q    <= b;
					r_q    <= '0;
					na_q   <= a[DATA_W-1] ? -a : a;
					nb_q   <= b[DATA_W-1] ? -b : b;
					nega_q <= a[DATA_W-1];
					negb_q <= b[DATA_W-1];
					ra_q   <= '0;
					rb_q   <= '0;
					cnt_q  <= '0;
				end
			end
			AR_RED: begin
				ra_q  <= ra_n;
				rb_q  <= rb_n;
				na_q  <= na_q << 1;
				nb_q  <= nb_q << 1;
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == '1) begin
					x_q <= DATA_W'(fa);
					y_q <= DATA_W'(fb);
					r_q <= '0;
				end
			end
			AR_MUL: begin
				r_q <= r_n;
				x_q <= x_n;
				y_q <= y_n;
			end
			AR_FIN: res_q <= fin;
			default: res_q <= res_q;
		endcase
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

### rtl/mmp_datapath.sv
`timescale 1ns / 1ps

module mmp_datapath import mmp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	output dp_status_t        status,
	input  logic [DATA_W-1:0] value_in,
	input  logic [EXP_W-1:0]  exponent_in,
	input  logic              mod_en,
	input  logic [MOD_W-1:0]  modulus,
	output logic [DIM_W-1:0]  out_row,
	output logic [DIM_W-1:0]  out_col,
	output logic [DATA_W-1:0] out_value,
	output logic              out_last,
	output logic              out_err
);

	logic [DATA_W-1:0] mem_q [MEM_DEPTH];
	logic [DATA_W-1:0] rd0_q, rd1_q, value_q, acc_q, wdata, ar_result, ar_acc;
	logic [EXP_W-1:0]  p_q;
	logic [MOD_W-1:0]  m_eff;
	logic              ar_done;
	logic [DIM_W-1:0]  orow_q, ocol_q;
	logic [DATA_W-1:0] oval_q;
	logic              olast_q, oerr_q;

	assign m_eff  = (modulus == '0) ? MOD_W'(1) : modulus;
	assign ar_acc = cmd.acc_zero ? '0 : acc_q;

	mmp_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.ar_start),
		.op     (cmd.ar_op),
		.a      (rd0_q),
		.b      (rd1_q),
		.acc    (ar_acc),
		.mod_en (mod_en),
		.m      (m_eff),
		.done   (ar_done),
		.result (ar_result)
	);

	always_comb begin
		case (cmd.wr_src)
			WS_VALUE: wdata = value_q;
			WS_ARITH: wdata = ar_result;
			WS_RD0:   wdata = rd0_q;
			WS_ONE:   wdata = DATA_W'(1);
			WS_ZERO:  wdata = '0;
			default:  wdata = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en)
			mem_q[cmd.wr_addr] <= wdata;
		if (cmd.rd_en) begin
			rd0_q <= mem_q[cmd.rd_addr0];
			rd1_q <= mem_q[cmd.rd_addr1];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			value_q <= value_in;
			p_q     <= exponent_in;
		end else if (cmd.p_shift) begin
			p_q <= p_q >> 1;
		end
		if (ar_done)
			acc_q <= ar_result;
		if (cmd.out_load) begin
			orow_q  <= cmd.out_row;
			ocol_q  <= cmd.out_col;
			oval_q  <= cmd.out_err ? '0 : rd0_q;
			olast_q <= cmd.out_last;
			oerr_q  <= cmd.out_err;
		end
	end

	assign status.ar_done   = ar_done;
	assign status.p_zero    = (p_q == '0);
	assign status.p_lsb     = p_q[0];
	assign status.p_hi_zero = (p_q[EXP_W-1:1] == '0);

	assign out_row   = orow_q;
	assign out_col   = ocol_q;
	assign out_value = oval_q;
	assign out_last  = olast_q;
	assign out_err   = oerr_q;

endmodule

### rtl/mmp_ctrl.sv
`timescale 1ns / 1ps

module mmp_ctrl import mmp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [FUNC_W-1:0] in_func,
	input  logic [DIM_W-1:0]  in_row,
	input  logic [DIM_W-1:0]  in_col,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  logic [DIM_W-1:0]  nr_m1,
	input  logic [DIM_W-1:0]  nk_m1,
	input  logic [DIM_W-1:0]  nc_m1,
	output dp_cmd_t           cmd,
	input  dp_status_t        status
);

	ctrl_state_t state_q, state_d;

	logic [FUNC_W-1:0]   func_q, func_d;
	logic [DIM_W-1:0]    row_q, row_d, col_q, col_d;
	logic [DIM_W-1:0]    i_q, i_d, j_q, j_d, k_q, k_d;
	logic [REGION_W-1:0] mmx_q, mmx_d, mmy_q, mmy_d, mmd_q, mmd_d;
	logic                acc_done_q, acc_done_d;

	logic                is_pow;
	logic [DIM_W-1:0]    em_cols, mm_k, mm_c;
	logic [REGION_W-1:0] em_region;
	logic                em_last, mm_last, pi_last;

	function automatic logic [2*DIM_W-1:0] next_ij(input logic [DIM_W-1:0] i,
		input logic [DIM_W-1:0] j, input logic [DIM_W-1:0] jmax);
		logic [2*DIM_W-1:0] r;
		if (j == jmax)
			r = {i + 1'b1, {DIM_W{1'b0}}};
		else
			r = {i, j + 1'b1};
		return r;
	endfunction

	assign is_pow    = (func_q == FN_POW);
	assign em_cols   = is_pow ? nr_m1 : nc_m1;
	assign em_region = is_pow ? RG_ACC : RG_SCR;
	assign mm_k      = is_pow ? nr_m1 : nk_m1;
	assign mm_c      = is_pow ? nr_m1 : nc_m1;
	assign em_last   = (i_q == nr_m1) && (j_q == em_cols);
	assign mm_last   = (i_q == nr_m1) && (j_q == mm_c);
	assign pi_last   = (i_q == nr_m1) && (j_q == nr_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			func_q     <= FN_LOAD_A;
			row_q      <= '0;
			col_q      <= '0;
			i_q        <= '0;
			j_q        <= '0;
			k_q        <= '0;
			mmx_q      <= RG_A;
			mmy_q      <= RG_B;
			mmd_q      <= RG_SCR;
			acc_done_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			func_q     <= func_d;
			row_q      <= row_d;
			col_q      <= col_d;
			i_q        <= i_d;
			j_q        <= j_d;
			k_q        <= k_d;
			mmx_q      <= mmx_d;
			mmy_q      <= mmy_d;
			mmd_q      <= mmd_d;
			acc_done_q <= acc_done_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		func_d     = func_q;
		row_d      = row_q;
		col_d      = col_q;
		i_d        = i_q;
		j_d        = j_q;
		k_d        = k_q;
		mmx_d      = mmx_q;
		mmy_d      = mmy_q;
		mmd_d      = mmd_q;
		acc_done_d = acc_done_q;
		cmd        = '0;
		in_ready   = 1'b0;
		out_valid  = 1'b0;

		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					func_d      = in_func;
					row_d       = in_row;
					col_d       = in_col;
					i_d         = '0;
					j_d         = '0;
					k_d         = '0;
					acc_done_d  = 1'b0;
					case (in_func)
						FN_LOAD_A, FN_LOAD_B: state_d = S_LOAD;
						FN_ADD, FN_SUB:       state_d = S_EW_RD;
						FN_MUL: begin
							mmx_d   = RG_A;
							mmy_d   = RG_B;
							mmd_d   = RG_SCR;
							state_d = S_MM_RD;
						end
						FN_POW:  state_d = (nr_m1 != nk_m1) ? S_ERR_LD : S_PI_RD;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_LOAD: begin
				cmd.wr_en   = ({1'b0, row_q} < 4'(MAX_DIM)) && ({1'b0, col_q} < 4'(MAX_DIM));
				cmd.wr_addr = {(func_q == FN_LOAD_A) ? RG_A : RG_B, row_q, col_q};
				cmd.wr_src  = WS_VALUE;
				state_d     = S_IDLE;
			end
			S_EW_RD: begin
				cmd.rd_en    = 1'b1;
				cmd.rd_addr0 = {RG_A, i_q, j_q};
				cmd.rd_addr1 = {RG_B, i_q, j_q};
				state_d      = S_EW_GO;
			end
			S_EW_GO: begin
				cmd.ar_start = 1'b1;
				cmd.ar_op    = (func_q == FN_ADD) ? AOP_ADD : AOP_SUB;
				state_d      = S_EW_WAIT;
			end
			S_EW_WAIT: begin
				if (status.ar_done) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_addr = {RG_SCR, i_q, j_q};
					cmd.wr_src  = WS_ARITH;
					if (em_last) begin
						i_d     = '0;
						j_d     = '0;
						state_d = S_EM_RD;
					end else begin
						{i_d, j_d} = next_ij(i_q, j_q, em_cols);
						state_d    = S_EW_RD;
					end
				end
			end
			S_MM_RD: begin
				cmd.rd_en    = 1'b1;
				cmd.rd_addr0 = {mmx_q, i_q, k_q};
				cmd.rd_addr1 = {mmy_q, k_q, j_q};
				state_d      = S_MM_GO;
			end
			S_MM_GO: begin
				cmd.ar_start = 1'b1;
				cmd.ar_op    = AOP_MAC;
				cmd.acc_zero = (k_q == '0);
				state_d      = S_MM_WAIT;
			end
			S_MM_WAIT: begin
				if (status.ar_done) begin
					if (k_q == mm_k) begin
						cmd.wr_en   = 1'b1;
						cmd.wr_addr = {RG_SCR, i_q, j_q};
						cmd.wr_src  = WS_ARITH;
						k_d         = '0;
						if (mm_last) begin
							i_d     = '0;
							j_d     = '0;
							state_d = (mmd_q == RG_SCR) ? S_MM_RET : S_CP_RD;
						end else begin
							{i_d, j_d} = next_ij(i_q, j_q, mm_c);
							state_d    = S_MM_RD;
						end
					end else begin
						k_d     = k_q + 1'b1;
						state_d = S_MM_RD;
					end
				end
			end
			S_CP_RD: begin
				cmd.rd_en    = 1'b1;
				cmd.rd_addr0 = {RG_SCR, i_q, j_q};
				cmd.rd_addr1 = {RG_SCR, i_q, j_q};
				state_d      = S_CP_WR;
			end
			S_CP_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = {mmd_q, i_q, j_q};
				cmd.wr_src  = WS_RD0;
				if (mm_last) begin
					i_d     = '0;
					j_d     = '0;
					state_d = S_MM_RET;
				end else begin
					{i_d, j_d} = next_ij(i_q, j_q, mm_c);
					state_d    = S_CP_RD;
				end
			end
			S_MM_RET: begin
				if (func_q == FN_MUL) begin
					state_d = S_EM_RD;
				end else begin
					if (mmd_q == RG_BASE) begin
						cmd.p_shift = 1'b1;
						acc_done_d  = 1'b0;
					end
					state_d = S_PW_CHK;
				end
			end
			S_PI_RD: begin
				cmd.rd_en    = 1'b1;
				cmd.rd_addr0 = {RG_A, i_q, j_q};
				cmd.rd_addr1 = {RG_A, i_q, j_q};
				state_d      = S_PI_WB;
			end
			S_PI_WB: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = {RG_BASE, i_q, j_q};
				cmd.wr_src  = WS_RD0;
				state_d     = S_PI_WI;
			end
			S_PI_WI: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = {RG_ACC, i_q, j_q};
				cmd.wr_src  = (i_q == j_q) ? WS_ONE : WS_ZERO;
				if (pi_last) begin
					i_d     = '0;
					j_d     = '0;
					state_d = S_PW_CHK;
				end else begin
					{i_d, j_d} = next_ij(i_q, j_q, nr_m1);
					state_d    = S_PI_RD;
				end
			end
			S_PW_CHK: begin
				i_d = '0;
				j_d = '0;
				k_d = '0;
				if (status.p_zero) begin
					state_d = S_EM_RD;
				end else if (status.p_lsb && !acc_done_q) begin
					acc_done_d = 1'b1;
					mmx_d      = RG_ACC;
					mmy_d      = RG_BASE;
					mmd_d      = RG_ACC;
					state_d    = S_MM_RD;
				end else if (status.p_hi_zero) begin
					cmd.p_shift = 1'b1;
					acc_done_d  = 1'b0;
				end else begin
					mmx_d   = RG_BASE;
					mmy_d   = RG_BASE;
					mmd_d   = RG_BASE;
					state_d = S_MM_RD;
				end
			end
			S_EM_RD: begin
				cmd.rd_en    = 1'b1;
				cmd.rd_addr0 = {em_region, i_q, j_q};
				cmd.rd_addr1 = {em_region, i_q, j_q};
				state_d      = S_EM_LD;
			end
			S_EM_LD: begin
				cmd.out_load = 1'b1;
				cmd.out_row  = i_q;
				cmd.out_col  = j_q;
				cmd.out_last = em_last;
				state_d      = S_EM_OUT;
			end
			S_EM_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (em_last) begin
						i_d     = '0;
						j_d     = '0;
						state_d = S_IDLE;
					end else begin
						{i_d, j_d} = next_ij(i_q, j_q, em_cols);
						state_d    = S_EM_RD;
					end
				end
			end
			S_ERR_LD: begin
				cmd.out_load = 1'b1;
				cmd.out_last = 1'b1;
				cmd.out_err  = 1'b1;
				state_d      = S_ERR_OUT;
			end
			S_ERR_OUT: begin
				out_valid = 1'b1;
				if (out_ready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

### rtl/modular_matrix_multiply_power_core.sv
`timescale 1ns / 1ps
// Channel  Dir  Beat fields
// item     in   func, row, col, value, exponent
// result   out  out_row, out_col, out_value, last, error
// cfg      in   cfg_we, cfg_index, cfg_wdata
//
// One item at a time; item.ready is high only while idle. A load is captured while idle
// and written in S_LOAD. An element operation runs in the shared arithmetic unit, which
// first reduces both operands when reduction is on; so does each multiply-accumulate.
// A product is rows*cols*inner of them; in power mode it is then copied to its target.
// Power runs up to 2*bitlength(exponent) products; a result beat is read, loaded, then offered.
// Reset is asynchronous; a stalled result beat holds until result.ready is high.

`include "modular_matrix_multiply_power_core_defines.svh"

module modular_matrix_multiply_power_core import mmp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	mmp_in_if.sink               item,
	mmp_out_if.source            result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [MOD_W-1:0]     cfg_wdata
);

	logic             mod_en_q;
	logic [MOD_W-1:0] modulus_q;
	logic [3:0]       rows_q, inner_q, cols_q;

	dp_cmd_t    cmd;
	dp_status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_en_q  <= 1'b1;
			modulus_q <= MODULUS_RESET;
			rows_q    <= 4'd1;
			inner_q   <= 4'd1;
			cols_q    <= 4'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MOD_EN:  mod_en_q  <= cfg_wdata[0];
				CFG_MODULUS: modulus_q <= cfg_wdata;
				CFG_ROWS_A:  rows_q    <= cfg_wdata[3:0];
				CFG_INNER:   inner_q   <= cfg_wdata[3:0];
				CFG_COLS_B:  cols_q    <= cfg_wdata[3:0];
				default:     mod_en_q  <= mod_en_q;
			endcase
		end
	end

	mmp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_func   (item.func),
		.in_row    (item.row),
		.in_col    (item.col),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.nr_m1     (clamp_dim(rows_q)),
		.nk_m1     (clamp_dim(inner_q)),
		.nc_m1     (clamp_dim(cols_q)),
		.cmd       (cmd),
		.status    (status)
	);

	mmp_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.value_in    (item.value),
		.exponent_in (item.exponent),
		.mod_en      (mod_en_q),
		.modulus     (modulus_q),
		.out_row     (result.out_row),
		.out_col     (result.out_col),
		.out_value   (result.out_value),
		.out_last    (result.last),
		.out_err     (result.error)
	);

	`MMP_NEVER(a_busy_exclusive, item.ready && result.valid, "Input ready while a result beat waits.")
	`MMP_CHECK(a_error_is_last, result.valid && result.error |-> result.last, "Error beat without last.")
	`MMP_CHECK(a_idle_after_last, result.valid && result.ready && result.last |=> item.ready, "Not idle after the last beat.")

endmodule
